[rtl/core/bitmap_slot_allocator_macros.svh]
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_macros
// Assertion shorthands shared by the slot allocator RTL. Each expects clk
// and rst_n in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes and types of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;
    localparam int SLOTS_DEF  = 4096;
    localparam int CFG_W      = 13;
    localparam int CFG_MAX    = 8191;
    localparam int SLOT_W     = 12;
    localparam int STATUS_W   = 2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DFREE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    // Outcome of one pass of the word unit.
    typedef struct packed {
        logic                  hit;
        logic [WORD_SHIFT-1:0] bit_idx;
        logic [WORD_BITS-1:0]  word;
    } unit_res_t;

endpackage

[rtl/core/bsa_if.sv]
// ----------------------------------------------------------------------------
// bsa_if
// Valid/ready channels of the slot allocator: request, response, config.
// ----------------------------------------------------------------------------
interface bsa_req_if import bsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output action, output slot, input ready);
    modport sink   (input valid, input action, input slot, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic [CFG_W-1:0]    free_count;

    modport source (output valid, output slot_out, output status, output free_count,
                    input ready);
    modport sink   (input valid, input slot_out, input status, input free_count,
                    output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] slot_count;

    modport source (output valid, output slot_count, input ready);
    modport sink   (input valid, input slot_count, output ready);
endinterface

[rtl/core/bsa_bitmap.sv]
// ----------------------------------------------------------------------------
// bsa_bitmap
// Occupancy word store: one write port, one registered read port. Words
// never written since reset read as zero through per-word valid bits.
// ----------------------------------------------------------------------------
module bsa_bitmap import bsa_pkg::*; #(
    parameter int WORDS = 64,
    parameter int WAW   = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [WAW-1:0]       rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [WAW-1:0]       wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] mem_reg [WORDS];
    logic [WORDS-1:0]     valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

[rtl/core/bsa_word_unit.sv]
// ----------------------------------------------------------------------------
// bsa_word_unit
// Shared word unit: masks unusable bits and finds the lowest clear bit for
// an allocate, or tests and clears one bit for a free.
// ----------------------------------------------------------------------------
module bsa_word_unit import bsa_pkg::*; #(
    parameter int WAW = 6,
    parameter int CW  = 13
) (
    input  logic                  op,
    input  logic [WORD_BITS-1:0]  word,
    input  logic [WAW-1:0]        widx,
    input  logic [CW-1:0]         eff,
    input  logic [WORD_SHIFT-1:0] fbit,
    output unit_res_t             res
);

    logic [CFG_W:0]          base;
    logic [CFG_W:0]          eff_x;
    logic [CFG_W:0]          span;
    logic [WORD_BITS-1:0]    mask;
    logic [WORD_BITS-1:0]    clear;
    logic [WORD_SHIFT-1:0]   low;
    logic [WORD_BITS-1:0]    one_hot;

    // Usable bits of this word: those below the effective slot count.
    always_comb
    begin
        base  = (CFG_W+1)'({widx, {WORD_SHIFT{1'b0}}});
        eff_x = (CFG_W+1)'(eff);
        span  = eff_x - base;
        if (base >= eff_x)
        begin
            mask = '0;
        end
        else if (span >= (CFG_W+1)'(WORD_BITS))
        begin
            mask = '1;
        end
        else
        begin
            mask = (WORD_BITS'(1) << span[WORD_SHIFT-1:0]) - WORD_BITS'(1);
        end
        clear = ~(word | ~mask);
    end

    always_comb
    begin
        low = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (clear[i])
            begin
                low = WORD_SHIFT'(i);
            end
        end
    end

    always_comb
    begin
        if (op == ACT_ALLOC)
        begin
            one_hot     = WORD_BITS'(1) << low;
            res.hit     = |clear;
            res.bit_idx = low;
            res.word    = word | one_hot;
        end
        else
        begin
            one_hot     = WORD_BITS'(1) << fbit;
            res.hit     = word[fbit];
            res.bit_idx = fbit;
            res.word    = word & ~one_hot;
        end
    end

endmodule

[rtl/core/bitmap_slot_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Next-fit slot allocator over an occupancy bitmap of 64-bit words. A small
// sequencer walks the bitmap one word per cycle through a shared word unit.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                          | beat taken when
//  --------+-----+----------------------------------+--------------------
//  cfg     | in  | slot_count                       | valid & ready (always ready)
//  req     | in  | action, slot                     | valid & ready
//  rsp     | out | slot_out, status, free_count     | valid & ready
//
//  A free is accepted (bitmap word read issued) and then evaluated.
//  An allocate is accepted, then examines words one per cycle (1 .. number
//  of usable words); the single read port of the bitmap sets that pace.
//  The request side is ready only while idle. The next request is taken
//  while a response waits; it then holds in evaluation until rsp drains.
//  Reset clears the valid bits of the bitmap at once: no clearing pass.
//
`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator import bsa_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bsa_cfg_if.sink     cfg,
    bsa_req_if.sink     req,
    bsa_rsp_if.source   rsp
);

    // Only slots below the widest slot_count value can ever be used.
    localparam int CAP   = (SLOTS < CFG_MAX) ? SLOTS : CFG_MAX;
    localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(CAP + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic                  state_reg, state_next;
    logic [CFG_W-1:0]      slot_count_reg;
    logic [WAW-1:0]        hint_reg, hint_next;
    logic [CW-1:0]         used_count_reg, used_count_next;

    // Per-request working registers (no reset needed).
    logic                  action_reg, action_next;
    logic [WORD_SHIFT-1:0] fbit_reg, fbit_next;
    logic                  oor_reg, oor_next;
    logic [WAW-1:0]        cur_w_reg, cur_w_next;
    logic [WAW:0]          pass_reg, pass_next;
    logic [WAW:0]          nwords_reg, nwords_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]     rsp_slot_reg;
    logic [STATUS_W-1:0]   rsp_status_reg;
    logic [CFG_W-1:0]      rsp_free_reg;

    logic [CW-1:0]         eff;
    logic [CFG_W:0]        round_up;
    logic [WAW:0]          nwords_calc;
    logic [WAW-1:0]        start_w;
    logic [CFG_W-1:0]      slot_ext;
    logic [CFG_W-WORD_SHIFT-1:0] slot_word;

    logic                  mem_rd_en;
    logic [WAW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0]  mem_rd_data;
    logic                  mem_wr_en;

    unit_res_t             unit_res;

    logic                  out_free;
    logic                  last_pass;
    logic                  finish;
    logic                  eval_go;
    logic                  advance;
    logic [STATUS_W-1:0]   res_status;
    logic [CFG_W-1:0]      slot_full;
    logic [WAW:0]          w_inc;
    logic [CW-1:0]         free_left;

    // Effective count: slot_count saturated to the capacity.
    assign eff         = (slot_count_reg > CFG_W'(CAP)) ? CW'(CAP) : CW'(slot_count_reg);
    assign round_up    = (CFG_W+1)'(eff) + (CFG_W+1)'(WORD_BITS - 1);
    assign nwords_calc = (WAW+1)'(round_up >> WORD_SHIFT);
    // A stale hint restarts the scan at word zero.
    assign start_w     = ((WAW+1)'(hint_reg) < nwords_calc) ? hint_reg : '0;
    assign slot_ext    = CFG_W'(req.slot);
    assign slot_word   = slot_ext[CFG_W-1:WORD_SHIFT];

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);

    bsa_bitmap #(
        .WORDS (WORDS),
        .WAW   (WAW)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (cur_w_reg),
        .wr_data (unit_res.word)
    );

    bsa_word_unit #(
        .WAW (WAW),
        .CW  (CW)
    ) u_unit (
        .op   (action_reg),
        .word (mem_rd_data),
        .widx (cur_w_reg),
        .eff  (eff),
        .fbit (fbit_reg),
        .res  (unit_res)
    );

    // Evaluation outcome of the current word.
    always_comb
    begin
        out_free  = !rsp_valid_reg || rsp.ready;
        last_pass = ((WAW+2)'(pass_reg) + (WAW+2)'(1)) >= (WAW+2)'(nwords_reg);
        if (action_reg == ACT_FREE)
        begin
            if (oor_reg)
            begin
                res_status = STAT_RANGE;
            end
            else if (!unit_res.hit)
            begin
                res_status = STAT_DFREE;
            end
            else
            begin
                res_status = STAT_OK;
            end
            finish = 1'b1;
        end
        else
        begin
            res_status = unit_res.hit ? STAT_OK : STAT_FULL;
            finish     = unit_res.hit || last_pass;
        end
        eval_go   = (state_reg == ST_EVAL) && finish && out_free;
        advance   = (state_reg == ST_EVAL) && !finish;
        mem_wr_en = eval_go && (res_status == STAT_OK);
        slot_full = CFG_W'({cur_w_reg, unit_res.bit_idx});
        w_inc     = (WAW+1)'(cur_w_reg) + (WAW+1)'(1);
    end

    // Count and hint after a granted request.
    always_comb
    begin
        used_count_next = used_count_reg;
        hint_next       = hint_reg;
        if (mem_wr_en)
        begin
            hint_next = cur_w_reg;
            if (action_reg == ACT_ALLOC)
            begin
                used_count_next = used_count_reg + CW'(1);
            end
            else if (used_count_reg != '0)
            begin
                used_count_next = used_count_reg - CW'(1);
            end
        end
        free_left = (eff > used_count_next) ? (eff - used_count_next) : '0;
    end

    // Sequencer: accept, then evaluate one word per cycle; the last word waits for a free response slot.
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        fbit_next   = fbit_reg;
        oor_next    = oor_reg;
        cur_w_next  = cur_w_reg;
        pass_next   = pass_reg;
        nwords_next = nwords_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = start_w;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    action_next = req.action;
                    fbit_next   = req.slot[WORD_SHIFT-1:0];
                    oor_next    = slot_ext >= CFG_W'(eff);
                    nwords_next = nwords_calc;
                    pass_next   = '0;
                    mem_rd_en   = 1'b1;
                    if (req.action == ACT_FREE)
                    begin
                        mem_rd_addr = slot_word[WAW-1:0];
                    end
                    cur_w_next = mem_rd_addr;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (advance)
                begin
                    // Step to the next word, wrapping at the usable word count.
                    pass_next   = pass_reg + (WAW+1)'(1);
                    cur_w_next  = (w_inc == nwords_reg) ? '0 : w_inc[WAW-1:0];
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_w_next;
                end
                else if (eval_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (eval_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= CFG_W'(SLOTS_DEF);
            hint_reg       <= '0;
            used_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hint_reg       <= hint_next;
            used_count_reg <= used_count_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg.valid)
            begin
                slot_count_reg <= cfg.slot_count;
            end
        end
    end

    // Hold the working set; load the response beat on completion.
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        fbit_reg   <= fbit_next;
        oor_reg    <= oor_next;
        cur_w_reg  <= cur_w_next;
        pass_reg   <= pass_next;
        nwords_reg <= nwords_next;
        if (eval_go)
        begin
            rsp_status_reg <= res_status;
            rsp_free_reg   <= CFG_W'(free_left);
            if ((action_reg == ACT_ALLOC) && (res_status == STAT_OK))
            begin
                rsp_slot_reg <= slot_full[SLOT_W-1:0];
            end
            else
            begin
                rsp_slot_reg <= '0;
            end
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.slot_out   = rsp_slot_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.free_count = rsp_free_reg;

    `BSA_ASSERT_NOW(a_rsp_from_eval, $rose(rsp_valid_reg), $past(state_reg) == ST_EVAL, "response raised outside evaluation")
    `BSA_ASSERT_NXT(a_fail_keeps_count, eval_go && res_status != STAT_OK, $stable(used_count_reg), "failed request changed the used count")
    `BSA_ASSERT_NXT(a_grant_sets_hint, eval_go && action_reg == ACT_ALLOC && unit_res.hit, hint_reg == $past(cur_w_reg), "grant did not move the hint")

endmodule
